/* src/joystick_sample_conditioner_macros.svh */
// Assertion macros used by the checker file.
`ifndef JOYSTICK_SAMPLE_CONDITIONER_MACROS_SVH
`define JOYSTICK_SAMPLE_CONDITIONER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define JSC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("jsc assertion failed");

// Next-cycle implication, disabled in reset.
`define JSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("jsc assertion failed");

`endif

/* src/jsc_pkg.sv */
// ----------------------------------------------------------------------------
// jsc_pkg
// Shared types and constants of the joystick sample conditioner.
// ----------------------------------------------------------------------------
package jsc_pkg;

    localparam int MAG_BITS       = 7;
    localparam int AXIS_OUT_BITS  = 8;
    localparam int DEB_BITS       = 4;
    localparam int CFG_INDEX_BITS = 3;

    // reset values are given for a 10-bit converter and rescaled to SAMPLE_BITS
    localparam int REF_SAMPLE_BITS = 10;
    localparam int UPPER_RESET_REF = 700;
    localparam int LOWER_RESET_REF = 300;
    localparam logic [MAG_BITS-1:0] MAG_LIMIT_RESET = 7'd100;
    localparam logic [DEB_BITS-1:0] DEBOUNCE_RESET  = 4'd3;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_UPPER_THRESHOLD = 3'd0,
        REG_LOWER_THRESHOLD = 3'd1,
        REG_MAGNITUDE_LIMIT = 3'd2,
        REG_DEBOUNCE_COUNT  = 3'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        DIR_CENTER = 3'd0,
        DIR_UP     = 3'd1,
        DIR_DOWN   = 3'd2,
        DIR_LEFT   = 3'd3,
        DIR_RIGHT  = 3'd4
    } dir_t;

    typedef struct packed {
        logic hi;
        logic lo;
        logic above;
    } axis_flags_t;

    typedef struct packed {
        logic down;
        logic press;
        logic release_edge;
    } button_status_t;

endpackage

/* src/jsc_ifs.sv */
// ----------------------------------------------------------------------------
// jsc interfaces
// Sample, result and register write channels (valid/ready).
// ----------------------------------------------------------------------------
interface jsc_sample_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
    logic                   button_level;

    modport source (output valid, x_sample, y_sample, button_level, input ready);
    modport sink   (input valid, x_sample, y_sample, button_level, output ready);
endinterface

interface jsc_result_if #(
    parameter int SAMPLE_BITS = 10,
    parameter int HOLD_BITS   = 16
);
    logic                                 valid;
    logic                                 ready;
    logic [SAMPLE_BITS-1:0]               x_value;
    logic [SAMPLE_BITS-1:0]               y_value;
    jsc_pkg::dir_t                        direction;
    logic [jsc_pkg::MAG_BITS-1:0]         magnitude;
    logic signed [jsc_pkg::AXIS_OUT_BITS-1:0] throttle;
    logic signed [jsc_pkg::AXIS_OUT_BITS-1:0] turn;
    logic                                 button_down;
    logic                                 press_edge;
    logic                                 release_edge;
    logic [HOLD_BITS-1:0]                 hold_ticks;

    modport source (output valid, x_value, y_value, direction, magnitude, throttle, turn,
                    button_down, press_edge, release_edge, hold_ticks, input ready);
    modport sink   (input valid, x_value, y_value, direction, magnitude, throttle, turn,
                    button_down, press_edge, release_edge, hold_ticks, output ready);
endinterface

interface jsc_cfg_if #(
    parameter int DATA_BITS = 10
);
    logic                                 valid;
    logic                                 ready;
    logic [jsc_pkg::CFG_INDEX_BITS-1:0]   index;
    logic [DATA_BITS-1:0]                 data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* src/jsc_cfg_regs.sv */
// ----------------------------------------------------------------------------
// jsc_cfg_regs
// Configuration register file; writes always accepted.
// ----------------------------------------------------------------------------
module jsc_cfg_regs #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic                            clk,
    input  logic                            rst_n,
    jsc_cfg_if.sink                         setup,
    output logic [SAMPLE_BITS-1:0]          upper_threshold,
    output logic [SAMPLE_BITS-1:0]          lower_threshold,
    output logic [jsc_pkg::MAG_BITS-1:0]    magnitude_limit,
    output logic [jsc_pkg::DEB_BITS-1:0]    debounce_count
);

    localparam int UPPER_RST =
        (jsc_pkg::UPPER_RESET_REF << SAMPLE_BITS) >> jsc_pkg::REF_SAMPLE_BITS;
    localparam int LOWER_RST =
        (jsc_pkg::LOWER_RESET_REF << SAMPLE_BITS) >> jsc_pkg::REF_SAMPLE_BITS;

    logic [SAMPLE_BITS-1:0]       upper_reg;
    logic [SAMPLE_BITS-1:0]       lower_reg;
    logic [jsc_pkg::MAG_BITS-1:0] limit_reg;
    logic [jsc_pkg::DEB_BITS-1:0] debounce_reg;
    logic                         write_en;

    assign setup.ready = 1'b1;
    assign write_en    = setup.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upper_reg    <= SAMPLE_BITS'(UPPER_RST);
            lower_reg    <= SAMPLE_BITS'(LOWER_RST);
            limit_reg    <= jsc_pkg::MAG_LIMIT_RESET;
            debounce_reg <= jsc_pkg::DEBOUNCE_RESET;
        end
        else if (write_en)
        begin
            unique case (setup.index)
                jsc_pkg::REG_UPPER_THRESHOLD: upper_reg <= setup.data;
                jsc_pkg::REG_LOWER_THRESHOLD: lower_reg <= setup.data;
                jsc_pkg::REG_MAGNITUDE_LIMIT: limit_reg <= setup.data[jsc_pkg::MAG_BITS-1:0];
                jsc_pkg::REG_DEBOUNCE_COUNT:  debounce_reg <= setup.data[jsc_pkg::DEB_BITS-1:0];
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    assign upper_threshold = upper_reg;
    assign lower_threshold = lower_reg;
    assign magnitude_limit = limit_reg;
    assign debounce_count  = debounce_reg;

endmodule

/* src/jsc_axis.sv */
// ----------------------------------------------------------------------------
// jsc_axis
// One axis: threshold flags, distance from center, scaled and signed values.
// ----------------------------------------------------------------------------
module jsc_axis #(
    parameter int SAMPLE_BITS = 10
) (
    input  logic [SAMPLE_BITS-1:0]                     value,
    input  logic [SAMPLE_BITS-1:0]                     upper_threshold,
    input  logic [SAMPLE_BITS-1:0]                     lower_threshold,
    input  logic [jsc_pkg::MAG_BITS-1:0]               magnitude_limit,
    output jsc_pkg::axis_flags_t                       flags,
    output logic [SAMPLE_BITS-1:0]                     distance,
    output logic [jsc_pkg::MAG_BITS-1:0]               scaled,
    output logic signed [jsc_pkg::AXIS_OUT_BITS-1:0]   signed_value
);

    localparam int PROD_BITS  = SAMPLE_BITS + jsc_pkg::MAG_BITS + 1;
    localparam int QUOT_BITS  = PROD_BITS - (SAMPLE_BITS - 1);
    localparam logic [SAMPLE_BITS-1:0] CENTER = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);
    localparam logic [PROD_BITS-1:0]   HALF   = PROD_BITS'(1) << (SAMPLE_BITS - 2);

    logic [PROD_BITS-1:0]                   product;
    logic [QUOT_BITS-1:0]                   quotient;
    logic [jsc_pkg::AXIS_OUT_BITS-1:0]      wide_mag;

    assign flags.hi    = value > upper_threshold;
    assign flags.lo    = value < lower_threshold;
    assign flags.above = value[SAMPLE_BITS-1];

    assign distance = flags.above ? (value - CENTER) : (CENTER - value);

    // round half up over half the sample range, then clip to the limit
    assign product  = PROD_BITS'(distance) * PROD_BITS'(magnitude_limit) + HALF;
    assign quotient = product[PROD_BITS-1:SAMPLE_BITS-1];
    assign scaled   = (quotient > QUOT_BITS'(magnitude_limit))
                      ? magnitude_limit : quotient[jsc_pkg::MAG_BITS-1:0];

    assign wide_mag     = {1'b0, scaled};
    assign signed_value = flags.above ? wide_mag : (~wide_mag + 1'b1);

endmodule

/* src/jsc_debounce.sv */
// ----------------------------------------------------------------------------
// jsc_debounce
// Button run-length debounce with edges and a saturating hold counter.
// ----------------------------------------------------------------------------
module jsc_debounce #(
    parameter int HOLD_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic                          pressed,
    input  logic [jsc_pkg::DEB_BITS-1:0]  debounce_count,
    output jsc_pkg::button_status_t       status,
    output logic [HOLD_BITS-1:0]          hold
);

    logic                         seeded_reg,   seeded_next;
    logic                         last_reg,     last_next;
    logic                         accepted_reg, accepted_next;
    logic [jsc_pkg::DEB_BITS-1:0] run_reg,      run_next;
    logic [HOLD_BITS-1:0]         hold_reg,     hold_next;
    logic                         first;
    logic                         last_cur;
    logic                         accepted_cur;
    logic [jsc_pkg::DEB_BITS-1:0] run_cur;

    always_comb
    begin
        // first request after reset seeds from its own level
        first        = !seeded_reg;
        last_cur     = first ? pressed : last_reg;
        accepted_cur = first ? pressed : accepted_reg;
        run_cur      = first ? '0 : run_reg;

        if (pressed == last_cur)
        begin
            last_next = last_cur;
            run_next  = (run_cur < debounce_count) ? run_cur + 1'b1 : run_cur;
        end
        else
        begin
            last_next = pressed;
            run_next  = '0;
        end

        accepted_next = (run_next >= debounce_count) ? pressed : accepted_cur;
        seeded_next   = 1'b1;

        if (accepted_next)
            hold_next = (&hold_reg) ? hold_reg : hold_reg + 1'b1;
        else
            hold_next = '0;

        // accepted_reg doubles as the previous debounced state
        status.down         = accepted_next;
        status.press        = !first && accepted_next && !accepted_reg;
        status.release_edge = !first && !accepted_next && accepted_reg;
        hold                = hold_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg   <= 1'b0;
            last_reg     <= 1'b0;
            accepted_reg <= 1'b0;
            run_reg      <= '0;
            hold_reg     <= '0;
        end
        else if (step)
        begin
            seeded_reg   <= seeded_next;
            last_reg     <= last_next;
            accepted_reg <= accepted_next;
            run_reg      <= run_next;
            hold_reg     <= hold_next;
        end
    end

endmodule

/* src/joystick_sample_conditioner.sv */
// ----------------------------------------------------------------------------
// joystick_sample_conditioner
// Joystick direction, scaled deflection and debounced button per sample set.
// ----------------------------------------------------------------------------
//  channel   | dir | payload
//  ----------+-----+---------------------------------------------------------
//  samples   | in  | x_sample, y_sample, button_level
//  report    | out | x_value, y_value, direction, magnitude, throttle, turn,
//            |     | button_down, press_edge, release_edge, hold_ticks
//  setup     | in  | index, data (register write, always ready)
//
//  One request per cycle sustained while report is ready; input register,
//  then result register. Per-axis scaling is one multiply between the two.
//  Reset clears valids, debounce state and the registers to their defaults.
//  A stall on report holds the result; the input register keeps taking
//  requests while the result register can drain in the same cycle.
// ----------------------------------------------------------------------------
module joystick_sample_conditioner #(
    parameter int SAMPLE_BITS = 10,
    parameter int HOLD_BITS   = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    jsc_sample_if.sink    samples,
    jsc_result_if.source  report,
    jsc_cfg_if.sink       setup
);

    logic [SAMPLE_BITS-1:0]       upper_threshold;
    logic [SAMPLE_BITS-1:0]       lower_threshold;
    logic [jsc_pkg::MAG_BITS-1:0] magnitude_limit;
    logic [jsc_pkg::DEB_BITS-1:0] debounce_count;

    // input register
    logic                   in_valid_reg, in_valid_next;
    logic [SAMPLE_BITS-1:0] in_x_reg;
    logic [SAMPLE_BITS-1:0] in_y_reg;
    logic                   in_btn_reg;
    logic                   in_take;
    logic                   advance;

    // result register
    logic                   out_valid_reg, out_valid_next;
    logic [SAMPLE_BITS-1:0] x_val_reg;
    logic [SAMPLE_BITS-1:0] y_val_reg;
    jsc_pkg::dir_t          dir_reg;
    logic [jsc_pkg::MAG_BITS-1:0]             mag_reg;
    logic signed [jsc_pkg::AXIS_OUT_BITS-1:0] throttle_reg;
    logic signed [jsc_pkg::AXIS_OUT_BITS-1:0] turn_reg;
    jsc_pkg::button_status_t                  btn_reg;
    logic [HOLD_BITS-1:0]                     hold_reg;

    logic [SAMPLE_BITS-1:0] y_inv;
    jsc_pkg::axis_flags_t   x_flags, y_flags;
    logic [SAMPLE_BITS-1:0] x_dist, y_dist;
    logic [jsc_pkg::MAG_BITS-1:0]             x_mag, y_mag;
    logic signed [jsc_pkg::AXIS_OUT_BITS-1:0] x_signed, y_signed;
    jsc_pkg::dir_t                            dir_next;
    jsc_pkg::button_status_t                  btn_next;
    logic [HOLD_BITS-1:0]                     hold_next;
    logic                                     x_active, y_active;

    jsc_cfg_regs #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
        .clk             (clk),
        .rst_n           (rst_n),
        .setup           (setup),
        .upper_threshold (upper_threshold),
        .lower_threshold (lower_threshold),
        .magnitude_limit (magnitude_limit),
        .debounce_count  (debounce_count)
    );

    assign advance       = in_valid_reg && (!out_valid_reg || report.ready);
    assign samples.ready = !in_valid_reg || advance;
    assign in_take       = samples.valid && samples.ready;

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        out_valid_next = advance ? 1'b1 : (report.ready ? 1'b0 : out_valid_reg);
    end

    assign y_inv = ~in_y_reg;

    jsc_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_x (
        .value           (in_x_reg),
        .upper_threshold (upper_threshold),
        .lower_threshold (lower_threshold),
        .magnitude_limit (magnitude_limit),
        .flags           (x_flags),
        .distance        (x_dist),
        .scaled          (x_mag),
        .signed_value    (x_signed)
    );

    jsc_axis #(.SAMPLE_BITS(SAMPLE_BITS)) u_axis_y (
        .value           (y_inv),
        .upper_threshold (upper_threshold),
        .lower_threshold (lower_threshold),
        .magnitude_limit (magnitude_limit),
        .flags           (y_flags),
        .distance        (y_dist),
        .scaled          (y_mag),
        .signed_value    (y_signed)
    );

    jsc_debounce #(.HOLD_BITS(HOLD_BITS)) u_debounce (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .pressed        (!in_btn_reg),
        .debounce_count (debounce_count),
        .status         (btn_next),
        .hold           (hold_next)
    );

    // both axes active: larger distance wins, ties to Y
    always_comb
    begin
        x_active = x_flags.hi || x_flags.lo;
        y_active = y_flags.hi || y_flags.lo;
        priority if (!x_active && !y_active)
            dir_next = jsc_pkg::DIR_CENTER;
        else if (y_active && (!x_active || y_dist >= x_dist))
            dir_next = y_flags.hi ? jsc_pkg::DIR_UP : jsc_pkg::DIR_DOWN;
        else
            dir_next = x_flags.hi ? jsc_pkg::DIR_RIGHT : jsc_pkg::DIR_LEFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_x_reg   <= samples.x_sample;
            in_y_reg   <= samples.y_sample;
            in_btn_reg <= samples.button_level;
        end
        if (advance)
        begin
            x_val_reg    <= in_x_reg;
            y_val_reg    <= y_inv;
            dir_reg      <= dir_next;
            // scaling is monotonic, so the larger scaled axis is the scaled max
            mag_reg      <= (x_mag > y_mag) ? x_mag : y_mag;
            throttle_reg <= y_signed;
            turn_reg     <= x_signed;
            btn_reg      <= btn_next;
            hold_reg     <= hold_next;
        end
    end

    assign report.valid        = out_valid_reg;
    assign report.x_value      = x_val_reg;
    assign report.y_value      = y_val_reg;
    assign report.direction    = dir_reg;
    assign report.magnitude    = mag_reg;
    assign report.throttle     = throttle_reg;
    assign report.turn         = turn_reg;
    assign report.button_down  = btn_reg.down;
    assign report.press_edge   = btn_reg.press;
    assign report.release_edge = btn_reg.release_edge;
    assign report.hold_ticks   = hold_reg;

endmodule

/* src/jsc_checker.sv */
// ----------------------------------------------------------------------------
// jsc_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "joystick_sample_conditioner_macros.svh"

module jsc_checker #(
    parameter int HOLD_BITS = 16
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 valid,
    input logic                 ready,
    input logic                 button_down,
    input logic                 press_edge,
    input logic                 release_edge,
    input logic [HOLD_BITS-1:0] hold_ticks
);

    `JSC_ASSERT_NEXT(a_stall_hold, clk, rst_n, valid && !ready, valid && $stable(hold_ticks) && $stable(button_down))
    `JSC_ASSERT_IMPL(a_edges_exclusive, clk, rst_n, valid, !(press_edge && release_edge))
    `JSC_ASSERT_IMPL(a_press_is_down, clk, rst_n, valid && press_edge, button_down && hold_ticks != '0)
    `JSC_ASSERT_IMPL(a_released_zero, clk, rst_n, valid && !button_down, hold_ticks == '0)

endmodule

bind joystick_sample_conditioner jsc_checker #(.HOLD_BITS(HOLD_BITS)) u_jsc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .valid        (report.valid),
    .ready        (report.ready),
    .button_down  (report.button_down),
    .press_edge   (report.press_edge),
    .release_edge (report.release_edge),
    .hold_ticks   (report.hold_ticks)
);

/* bench/tb_joystick_sample_conditioner.sv */
// ----------------------------------------------------------------------------
// tb_joystick_sample_conditioner
// Drives sample sets through the joystick conditioner under random flow
// control and several register settings. A behavioral predictor tracks the
// debounce state and the registers, and each report is checked field by
// field against the oldest predicted report.
// ----------------------------------------------------------------------------
module tb_joystick_sample_conditioner;

    localparam int SAMPLE_BITS   = 10;
    localparam int HOLD_BITS     = 16;
    localparam int FULL_SCALE    = (1 << SAMPLE_BITS) - 1;
    localparam int CENTER        = 1 << (SAMPLE_BITS - 1);
    localparam int HOLD_MAX      = (1 << HOLD_BITS) - 1;
    localparam int REG_COUNT     = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_STALL    = 300;
    localparam int HELD_ITEMS    = 20;
    localparam int RUN_LIMIT     = 400000;

    typedef struct {
        logic [SAMPLE_BITS-1:0] x;
        logic [SAMPLE_BITS-1:0] y;
        logic                   btn;
    } joy_sample_t;

    typedef struct {
        logic [SAMPLE_BITS-1:0]                   x_value;
        logic [SAMPLE_BITS-1:0]                   y_value;
        jsc_pkg::dir_t                            direction;
        logic [jsc_pkg::MAG_BITS-1:0]             magnitude;
        logic signed [jsc_pkg::AXIS_OUT_BITS-1:0] throttle;
        logic signed [jsc_pkg::AXIS_OUT_BITS-1:0] turn;
        logic                                     button_down;
        logic                                     press_edge;
        logic                                     release_edge;
        logic [HOLD_BITS-1:0]                     hold_ticks;
    } joy_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    jsc_sample_if #(.SAMPLE_BITS(SAMPLE_BITS)) samples();
    jsc_result_if #(.SAMPLE_BITS(SAMPLE_BITS), .HOLD_BITS(HOLD_BITS)) report();
    jsc_cfg_if    #(.DATA_BITS(SAMPLE_BITS)) setup();

    joystick_sample_conditioner #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .HOLD_BITS  (HOLD_BITS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .samples(samples),
        .report (report),
        .setup  (setup)
    );

    always #6 clk = ~clk;

    joy_sample_t pending_samples[$];
    joy_report_t expected_reports[$];

    bit failed       = 1'b0;
    bit sample_taken = 1'b0;
    bit cfg_taken    = 1'b0;
    bit idle_now     = 1'b0;
    bit recv_hold    = 1'b0;
    bit stall_go     = 1'b0;
    bit btn_steady   = 1'b1;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    // predictor copy of the registers
    logic [SAMPLE_BITS-1:0]          thr_upper = SAMPLE_BITS'(jsc_pkg::UPPER_RESET_REF);
    logic [SAMPLE_BITS-1:0]          thr_lower = SAMPLE_BITS'(jsc_pkg::LOWER_RESET_REF);
    logic [jsc_pkg::MAG_BITS-1:0]    mag_limit = jsc_pkg::MAG_LIMIT_RESET;
    logic [jsc_pkg::DEB_BITS-1:0]    deb_count = jsc_pkg::DEBOUNCE_RESET;

    // predictor copy of the button state
    logic                            deb_last     = 1'b0;
    logic                            deb_accepted = 1'b0;
    logic [jsc_pkg::DEB_BITS-1:0]    deb_run      = '0;
    logic                            deb_prev     = 1'b0;
    logic                            deb_seeded   = 1'b0;
    int unsigned                     hold_count   = 0;

    function automatic int unsigned off_center(input int unsigned v);
        return (v >= CENTER) ? v - CENTER : CENTER - v;
    endfunction

    function automatic int unsigned scaled(input int unsigned d);
        int unsigned m;
        m = (d * mag_limit + CENTER / 2) / CENTER;
        return (m > mag_limit) ? mag_limit : m;
    endfunction

    function automatic logic signed [jsc_pkg::AXIS_OUT_BITS-1:0] deflection(
        input int unsigned v);
        logic [jsc_pkg::AXIS_OUT_BITS-1:0] m;
        m = jsc_pkg::AXIS_OUT_BITS'(scaled(off_center(v)));
        return (v >= CENTER) ? m : -m;
    endfunction

    function automatic jsc_pkg::dir_t classify_dir(input int unsigned x, input int unsigned y);
        bit xh, xl, yh, yl, xa, ya;
        xh = x > thr_upper;
        xl = x < thr_lower;
        yh = y > thr_upper;
        yl = y < thr_lower;
        xa = xh || xl;
        ya = yh || yl;
        if (!xa && !ya)
            return jsc_pkg::DIR_CENTER;
        // both axes active: farther axis wins, a tie goes to Y
        if (ya && (!xa || off_center(y) >= off_center(x)))
            return yh ? jsc_pkg::DIR_UP : jsc_pkg::DIR_DOWN;
        return xh ? jsc_pkg::DIR_RIGHT : jsc_pkg::DIR_LEFT;
    endfunction

    function automatic joy_report_t predict_report(input joy_sample_t s);
        joy_report_t r;
        int unsigned xv, yv, dx, dy;
        logic pressed;
        bit first;
        xv = s.x;
        yv = FULL_SCALE - s.y;
        pressed = ~s.btn;
        dx = off_center(xv);
        dy = off_center(yv);
        first = !deb_seeded;

        // first request after reset seeds the debouncer from its own level
        if (first)
        begin
            deb_last = pressed;
            deb_accepted = pressed;
            deb_run = '0;
        end
        if (pressed == deb_last)
        begin
            if (deb_run < deb_count)
                deb_run = deb_run + 1'b1;
        end
        else
        begin
            deb_run = '0;
            deb_last = pressed;
        end
        if (deb_run >= deb_count)
            deb_accepted = pressed;

        r.press_edge   = !first && deb_accepted && !deb_prev;
        r.release_edge = !first && !deb_accepted && deb_prev;
        deb_seeded = 1'b1;

        if (deb_accepted)
        begin
            if (hold_count < HOLD_MAX)
                hold_count++;
        end
        else
            hold_count = 0;
        deb_prev = deb_accepted;

        r.x_value     = xv[SAMPLE_BITS-1:0];
        r.y_value     = yv[SAMPLE_BITS-1:0];
        r.direction   = classify_dir(xv, yv);
        r.magnitude   = jsc_pkg::MAG_BITS'(scaled(dx > dy ? dx : dy));
        r.throttle    = deflection(yv);
        r.turn        = deflection(xv);
        r.button_down = deb_accepted;
        r.hold_ticks  = hold_count[HOLD_BITS-1:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            failed = 1'b1;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // request driver
    always @(negedge clk)
    begin : sample_driver
        joy_sample_t nxt;
        if (!rst_n)
            samples.valid <= 1'b0;
        else if (!samples.valid || sample_taken)
        begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_samples.pop_front();
                samples.valid        <= 1'b1;
                samples.x_sample     <= nxt.x;
                samples.y_sample     <= nxt.y;
                samples.button_level <= nxt.btn;
            end
            else
                samples.valid <= 1'b0;
        end
    end

    // report receiver
    always @(negedge clk)
    begin
        if (!rst_n || recv_hold)
            report.ready <= 1'b0;
        else
            report.ready <= $urandom_range(99) >= recv_idle_pct;
    end

    initial
    begin : receiver_stall
        wait (stall_go);
        recv_hold = 1'b1;
        repeat (LONG_STALL) @(posedge clk);
        recv_hold = 1'b0;
    end

    // monitor: predicts on accepted requests, checks accepted reports
    always @(posedge clk)
    begin : report_monitor
        joy_report_t want;
        if (!rst_n)
        begin
            sample_taken <= 1'b0;
            cfg_taken    <= 1'b0;
            idle_now = 1'b0;
        end
        else
        begin
            sample_taken <= samples.valid && samples.ready;
            cfg_taken    <= setup.valid && setup.ready;
            if (setup.valid && setup.ready)
            begin
                case (setup.index)
                    jsc_pkg::REG_UPPER_THRESHOLD: thr_upper = setup.data[SAMPLE_BITS-1:0];
                    jsc_pkg::REG_LOWER_THRESHOLD: thr_lower = setup.data[SAMPLE_BITS-1:0];
                    jsc_pkg::REG_MAGNITUDE_LIMIT:
                        mag_limit = setup.data[jsc_pkg::MAG_BITS-1:0];
                    jsc_pkg::REG_DEBOUNCE_COUNT:
                        deb_count = setup.data[jsc_pkg::DEB_BITS-1:0];
                    default: ;
                endcase
            end
            if (samples.valid && samples.ready)
                expected_reports.push_back(predict_report('{samples.x_sample,
                    samples.y_sample, samples.button_level}));
            if (report.valid && report.ready)
            begin
                if (expected_reports.size() == 0)
                begin
                    failed = 1'b1;
                    $display("%0t: report expected none actual x %0d y %0d", $time,
                             report.x_value, report.y_value);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    check_field("x_value", want.x_value, report.x_value);
                    check_field("y_value", want.y_value, report.y_value);
                    check_field("direction", want.direction, report.direction);
                    check_field("magnitude", want.magnitude, report.magnitude);
                    check_field("throttle", want.throttle, report.throttle);
                    check_field("turn", want.turn, report.turn);
                    check_field("button_down", want.button_down, report.button_down);
                    check_field("press_edge", want.press_edge, report.press_edge);
                    check_field("release_edge", want.release_edge, report.release_edge);
                    check_field("hold_ticks", want.hold_ticks, report.hold_ticks);
                end
            end
            idle_now = pending_samples.size() == 0 && !samples.valid
                       && expected_reports.size() == 0;
        end
    end

    task automatic add_sample(input int unsigned x, input int unsigned y, input logic btn);
        pending_samples.push_back('{x[SAMPLE_BITS-1:0], y[SAMPLE_BITS-1:0], btn});
    endtask

    // axis value biased toward the ends, the center and the thresholds
    function automatic logic [SAMPLE_BITS-1:0] pick_axis();
        int unsigned v;
        case ($urandom_range(7))
            0: v = FULL_SCALE;
            1: v = 0;
            2: v = CENTER - $urandom_range(1);
            3: v = thr_upper + $urandom_range(2) - 1;
            4: v = thr_lower + $urandom_range(2) - 1;
            default: v = $urandom_range(FULL_SCALE);
        endcase
        return v[SAMPLE_BITS-1:0];
    endfunction

    // button mostly follows steady runs, with occasional glitches
    function automatic logic pick_button();
        if ($urandom_range(15) == 0)
            return $urandom_range(1);
        if ($urandom_range(9) == 0)
            btn_steady = ~btn_steady;
        return btn_steady;
    endfunction

    task automatic wait_idle();
        @(posedge clk);
        do
            @(negedge clk);
        while (!idle_now);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic random_phase(input int n);
        repeat (n)
            add_sample(pick_axis(), ~pick_axis(), pick_button());
        wait_idle();
    endtask

    task automatic write_reg(input logic [jsc_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [SAMPLE_BITS-1:0] val);
        @(negedge clk);
        setup.valid <= 1'b1;
        setup.index <= idx;
        setup.data  <= val;
        do
            @(negedge clk);
        while (!cfg_taken);
        setup.valid <= 1'b0;
    endtask

    task automatic write_random_regs();
        write_reg(jsc_pkg::REG_UPPER_THRESHOLD, SAMPLE_BITS'($urandom));
        write_reg(jsc_pkg::REG_LOWER_THRESHOLD, SAMPLE_BITS'($urandom));
        write_reg(jsc_pkg::REG_MAGNITUDE_LIMIT, SAMPLE_BITS'($urandom));
        write_reg(jsc_pkg::REG_DEBOUNCE_COUNT, SAMPLE_BITS'($urandom));
    endtask

    initial
    begin : stimulus
        samples.valid        = 1'b0;
        samples.x_sample     = '0;
        samples.y_sample     = '0;
        samples.button_level = 1'b1;
        report.ready         = 1'b0;
        setup.valid          = 1'b0;
        setup.index          = '0;
        setup.data           = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_idle_pct = 28;
        recv_idle_pct = 63;

        // directed: seeding, every direction, ties, threshold edges, debounce
        add_sample(CENTER, CENTER - 1, 1'b1);
        add_sample(0, CENTER - 1, 1'b0);
        add_sample(FULL_SCALE, CENTER - 1, 1'b0);
        add_sample(CENTER, 0, 1'b0);
        add_sample(CENTER, FULL_SCALE, 1'b0);
        add_sample(100, 99, 1'b0);
        add_sample(1000, FULL_SCALE, 1'b0);
        add_sample(FULL_SCALE, 300, 1'b0);
        add_sample(700, 323, 1'b1);
        add_sample(701, 724, 1'b1);
        add_sample(300, 723, 1'b1);
        add_sample(299, FULL_SCALE, 1'b1);
        add_sample(CENTER - 1, CENTER, 1'b1);
        add_sample(CENTER + 1, CENTER - 2, 1'b1);
        add_sample(CENTER, CENTER - 1, 1'b0);
        add_sample(CENTER, CENTER - 1, 1'b1);
        add_sample(CENTER, CENTER - 1, 1'b0);
        add_sample(CENTER, CENTER - 1, 1'b0);
        random_phase(150);

        // widest thresholds, largest limit, longest debounce
        write_reg(jsc_pkg::REG_UPPER_THRESHOLD, SAMPLE_BITS'(FULL_SCALE));
        write_reg(jsc_pkg::REG_LOWER_THRESHOLD, SAMPLE_BITS'(0));
        write_reg(jsc_pkg::REG_MAGNITUDE_LIMIT, 10'h07F);
        write_reg(jsc_pkg::REG_DEBOUNCE_COUNT, 10'h00F);
        random_phase(100);

        // crossed thresholds, limit one, debounce one; upper data bits masked
        write_reg(jsc_pkg::REG_UPPER_THRESHOLD, SAMPLE_BITS'(200));
        write_reg(jsc_pkg::REG_LOWER_THRESHOLD, SAMPLE_BITS'(800));
        write_reg(jsc_pkg::REG_MAGNITUDE_LIMIT, 10'h381);
        write_reg(jsc_pkg::REG_DEBOUNCE_COUNT, 10'h3F1);
        random_phase(100);

        send_idle_pct = 63;
        recv_idle_pct = 28;

        // zero limit and zero debounce; writes past the last register do nothing
        write_reg(jsc_pkg::REG_UPPER_THRESHOLD, SAMPLE_BITS'(0));
        write_reg(jsc_pkg::REG_LOWER_THRESHOLD, SAMPLE_BITS'(FULL_SCALE));
        write_reg(jsc_pkg::REG_MAGNITUDE_LIMIT, 10'h380);
        write_reg(jsc_pkg::REG_DEBOUNCE_COUNT, 10'h3F0);
        for (int i = REG_COUNT; i < (1 << jsc_pkg::CFG_INDEX_BITS); i++)
            write_reg(i[jsc_pkg::CFG_INDEX_BITS-1:0], SAMPLE_BITS'($urandom));
        random_phase(60);
        random_phase(60);

        write_random_regs();
        random_phase(100);
        write_random_regs();
        random_phase(100);

        send_idle_pct = 0;
        recv_idle_pct = 0;

        // reset-value settings with a long report stall while requests keep coming
        write_reg(jsc_pkg::REG_UPPER_THRESHOLD, SAMPLE_BITS'(jsc_pkg::UPPER_RESET_REF));
        write_reg(jsc_pkg::REG_LOWER_THRESHOLD, SAMPLE_BITS'(jsc_pkg::LOWER_RESET_REF));
        write_reg(jsc_pkg::REG_MAGNITUDE_LIMIT, SAMPLE_BITS'(jsc_pkg::MAG_LIMIT_RESET));
        write_reg(jsc_pkg::REG_DEBOUNCE_COUNT, SAMPLE_BITS'(jsc_pkg::DEBOUNCE_RESET));
        stall_go = 1'b1;
        random_phase(180);

        write_random_regs();
        random_phase(180);

        // button held for a stretch, then released
        write_reg(jsc_pkg::REG_DEBOUNCE_COUNT, 10'h001);
        repeat (HELD_ITEMS)
            add_sample(pick_axis(), ~pick_axis(), 1'b0);
        repeat (4)
            add_sample(pick_axis(), ~pick_axis(), 1'b1);
        wait_idle();

        repeat (2 * SETTLE_CYCLES) @(negedge clk);
        if (!failed)
            $display("joystick_sample_conditioner: match");
        else
            $display("joystick_sample_conditioner: mismatch");
        $finish;
    end

    initial
    begin : watchdog
        #(12 * RUN_LIMIT);
        $display("joystick_sample_conditioner: mismatch");
        $finish;
    end

endmodule

/* joystick_sample_conditioner.f */
+incdir+src
src/jsc_pkg.sv
src/jsc_ifs.sv
src/jsc_cfg_regs.sv
src/jsc_axis.sv
src/jsc_debounce.sv
src/joystick_sample_conditioner.sv
src/jsc_checker.sv
bench/tb_joystick_sample_conditioner.sv
